>>> rtl/rgbts_pkg.sv
// ----------------------------------------------------------------------------
// rgbts_pkg
// Shared constants, codes and types of the range-gated best target selector.
// ----------------------------------------------------------------------------
package rgbts_pkg;

  localparam int SLOT_COUNT    = 1024;
  localparam int PROGRESS_STEP = 1000;

  localparam int SLOT_W   = 10;
  localparam int GEN_W    = 16;
  localparam int COORD_W  = 16;
  localparam int VAL_W    = 16;
  localparam int PROG_W   = 27;
  localparam int SCORE_W  = 36;
  localparam int DIST_W   = 33;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_STEALTH = 3'd4;

  localparam logic [MODE_W-1:0] MODE_FIRST     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LAST      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLOSEST   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STRONGEST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WEAKEST   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REWARD    = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [VAL_W-1:0]          reach;
    logic [MODE_W-1:0]         score_mode;
    logic                      ignore_stealth;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot_id;
    logic [GEN_W-1:0]          gen_tag;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [VAL_W-1:0]          health;
    logic [VAL_W-1:0]          reward;
    logic [VAL_W-1:0]          waypoint;
    logic                      live;
    logic                      stealthy;
    logic                      revealed;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic                      counts;
    logic                      last;
    logic signed [SCORE_W-1:0] score;
    logic [PROG_W-1:0]         progress;
    logic [SLOT_W-1:0]         slot_id;
    logic [GEN_W-1:0]          gen_tag;
  } cand_t;

endpackage

>>> rtl/rgbts_eval.sv
// ----------------------------------------------------------------------------
// rgbts_eval
// Input register and candidate evaluation: eligibility, range gate and score.
// ----------------------------------------------------------------------------
module rgbts_eval (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rgbts_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rgbts_pkg::item_t      in_item,
  output logic                  cand_valid,
  input  logic                  cand_stall,
  output rgbts_pkg::cand_t      cand
);

  logic                     s0_valid_r, s0_valid_nxt;
  rgbts_pkg::item_t         s0_r;
  logic                     s1_valid_r, s1_valid_nxt;
  rgbts_pkg::cand_t         s1_r, s1_nxt;
  logic                     s0_free, s1_free;

  logic signed [16:0]       dx, dy;
  logic signed [33:0]       dx_sq, dy_sq;
  logic [rgbts_pkg::DIST_W-1:0] dist_sq;
  logic [31:0]              reach_sq;
  logic [rgbts_pkg::PROG_W-1:0] progress;
  logic signed [rgbts_pkg::SCORE_W-1:0] prog_s, dist_s, health_s, reward_s;
  logic                     slot_ok, eligible, in_range;

  assign s1_free  = !s1_valid_r || !cand_stall;
  assign s0_free  = !s0_valid_r || s1_free;
  assign in_stall = !s0_free;
  assign s0_valid_nxt = s0_free ? in_valid : 1'b1;
  assign s1_valid_nxt = s1_free ? s0_valid_r : 1'b1;

  always_comb begin
    slot_ok  = {7'd0, s0_r.slot_id} < 17'(rgbts_pkg::SLOT_COUNT);
    eligible = s0_r.live && slot_ok &&
               (cfg.ignore_stealth || !s0_r.stealthy || s0_r.revealed);
    dx       = {cfg.center_x[15], cfg.center_x} - {s0_r.pos_x[15], s0_r.pos_x};
    dy       = {cfg.center_y[15], cfg.center_y} - {s0_r.pos_y[15], s0_r.pos_y};
    dx_sq    = dx * dx;
    dy_sq    = dy * dy;
    dist_sq  = {1'b0, dx_sq[31:0]} + {1'b0, dy_sq[31:0]};
    reach_sq = {16'd0, cfg.reach} * {16'd0, cfg.reach};
    in_range = dist_sq <= {1'b0, reach_sq};
    progress = 27'(s0_r.waypoint) * 27'(rgbts_pkg::PROGRESS_STEP);
    prog_s   = $signed({9'd0, progress});
    dist_s   = $signed({3'd0, dist_sq});
    health_s = $signed({20'd0, s0_r.health});
    reward_s = $signed({20'd0, s0_r.reward});

    s1_nxt.counts   = eligible && in_range;
    s1_nxt.last     = s0_r.last;
    s1_nxt.progress = progress;
    s1_nxt.slot_id  = s0_r.slot_id;
    s1_nxt.gen_tag  = s0_r.gen_tag;
    unique case (cfg.score_mode)
      rgbts_pkg::MODE_LAST:      s1_nxt.score = -prog_s;
      rgbts_pkg::MODE_CLOSEST:   s1_nxt.score = -dist_s;
      rgbts_pkg::MODE_STRONGEST: s1_nxt.score = health_s;
      rgbts_pkg::MODE_WEAKEST:   s1_nxt.score = -health_s;
      rgbts_pkg::MODE_REWARD:    s1_nxt.score = reward_s;
      default:                   s1_nxt.score = prog_s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_free && in_valid) begin
      s0_r <= in_item;
    end
    if (s1_free && s0_valid_r) begin
      s1_r <= s1_nxt;
    end
  end

  assign cand_valid = s1_valid_r;
  assign cand       = s1_r;

endmodule

>>> rtl/rgbts_best.sv
// ----------------------------------------------------------------------------
// rgbts_best
// Running best candidate and the result register of a completed search.
// ----------------------------------------------------------------------------
module rgbts_best (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cand_valid,
  output logic                         cand_stall,
  input  rgbts_pkg::cand_t             cand,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [rgbts_pkg::SLOT_W-1:0] out_chosen_slot,
  output logic [rgbts_pkg::GEN_W-1:0]  out_chosen_gen
);

  logic                                have_best_r, have_best_nxt;
  logic signed [rgbts_pkg::SCORE_W-1:0] lead_score_r, lead_score_nxt;
  logic [rgbts_pkg::PROG_W-1:0]        lead_prog_r, lead_prog_nxt;
  logic [rgbts_pkg::SLOT_W-1:0]        best_slot_r, best_slot_nxt;
  logic [rgbts_pkg::GEN_W-1:0]         best_gen_r, best_gen_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_found_r;
  logic [rgbts_pkg::SLOT_W-1:0]        out_slot_r;
  logic [rgbts_pkg::GEN_W-1:0]         out_gen_r;
  logic                                take, fire, fire_last;

  assign cand_stall = cand_valid && cand.last && out_valid_r && out_stall;
  assign fire       = cand_valid && !cand_stall;
  assign fire_last  = fire && cand.last;

  always_comb begin
    take = cand.counts &&
           (!have_best_r || (cand.score > lead_score_r) ||
            ((cand.score == lead_score_r) && (cand.progress > lead_prog_r)));
    have_best_nxt  = have_best_r || take;
    lead_score_nxt = take ? cand.score    : lead_score_r;
    lead_prog_nxt  = take ? cand.progress : lead_prog_r;
    best_slot_nxt  = take ? cand.slot_id  : best_slot_r;
    best_gen_nxt   = take ? cand.gen_tag  : best_gen_r;
    out_valid_nxt  = fire_last || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        have_best_r <= fire_last ? 1'b0 : have_best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lead_score_r <= lead_score_nxt;
      lead_prog_r  <= lead_prog_nxt;
      best_slot_r  <= best_slot_nxt;
      best_gen_r   <= best_gen_nxt;
    end
    if (fire_last) begin
      out_found_r <= have_best_nxt;
      out_slot_r  <= have_best_nxt ? best_slot_nxt : '0;
      out_gen_r   <= have_best_nxt ? best_gen_nxt  : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_chosen_slot = out_slot_r;
  assign out_chosen_gen  = out_gen_r;

endmodule

>>> rtl/range_gated_best_target_select.sv
// ----------------------------------------------------------------------------
// range_gated_best_target_select
// Streams candidate items and reports the best one in range for each search.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while in_stall is low. An item passes
// through an input register, an evaluation register (range gate by squared
// distance and score) and the running-best update, after which a search closed
// by an item marked last presents its result in the result register. A held
// result stalls only an item marked last when it reaches the update; items
// ahead of it keep flowing and items behind it wait.
module range_gated_best_target_select (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [rgbts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgbts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rgbts_pkg::SLOT_W-1:0]          in_slot_id,
  input  logic [rgbts_pkg::GEN_W-1:0]           in_gen_tag,
  input  logic signed [rgbts_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [rgbts_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [rgbts_pkg::VAL_W-1:0]           in_health,
  input  logic [rgbts_pkg::VAL_W-1:0]           in_reward,
  input  logic [rgbts_pkg::VAL_W-1:0]           in_waypoint,
  input  logic                                  in_live,
  input  logic                                  in_stealthy,
  input  logic                                  in_revealed,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic [rgbts_pkg::SLOT_W-1:0]          out_chosen_slot,
  output logic [rgbts_pkg::GEN_W-1:0]           out_chosen_gen
);

  rgbts_pkg::cfg_t  cfg_r;
  rgbts_pkg::item_t in_item;
  rgbts_pkg::cand_t cand;
  logic             cand_valid, cand_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rgbts_pkg::CFG_CENTER_X:       cfg_r.center_x       <= $signed(cfg_wdata);
        rgbts_pkg::CFG_CENTER_Y:       cfg_r.center_y       <= $signed(cfg_wdata);
        rgbts_pkg::CFG_REACH:          cfg_r.reach          <= cfg_wdata;
        rgbts_pkg::CFG_SCORE_MODE:     cfg_r.score_mode     <= cfg_wdata[2:0];
        rgbts_pkg::CFG_IGNORE_STEALTH: cfg_r.ignore_stealth <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.slot_id  = in_slot_id;
    in_item.gen_tag  = in_gen_tag;
    in_item.pos_x    = in_pos_x;
    in_item.pos_y    = in_pos_y;
    in_item.health   = in_health;
    in_item.reward   = in_reward;
    in_item.waypoint = in_waypoint;
    in_item.live     = in_live;
    in_item.stealthy = in_stealthy;
    in_item.revealed = in_revealed;
    in_item.last     = in_last;
  end

  rgbts_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand)
  );

  rgbts_best u_best (
    .clk             (clk),
    .rst_n           (rst_n),
    .cand_valid      (cand_valid),
    .cand_stall      (cand_stall),
    .cand            (cand),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_chosen_slot (out_chosen_slot),
    .out_chosen_gen  (out_chosen_gen)
  );

endmodule

>>> dv/range_gated_best_target_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_gated_best_target_select_tb
// Self-checking testbench for the range-gated best target selector. Searches
// of candidate items are streamed in under random sender gaps and receiver
// stalls. A running-best predictor kept alongside the block works out the
// result of each search, and every result is compared field by field.
// ----------------------------------------------------------------------------
module range_gated_best_target_select_tb;

  localparam int CLK_HALF     = 10;
  localparam int SETTLE       = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASES       = 10;

  localparam logic [rgbts_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [rgbts_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic                         found;
    logic [rgbts_pkg::SLOT_W-1:0] slot;
    logic [rgbts_pkg::GEN_W-1:0]  gen;
  } verdict_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_wr_en;
  logic [rgbts_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [rgbts_pkg::CFG_DATA_W-1:0]     cfg_wdata;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [rgbts_pkg::SLOT_W-1:0]         in_slot_id;
  logic [rgbts_pkg::GEN_W-1:0]          in_gen_tag;
  logic signed [rgbts_pkg::COORD_W-1:0] in_pos_x;
  logic signed [rgbts_pkg::COORD_W-1:0] in_pos_y;
  logic [rgbts_pkg::VAL_W-1:0]          in_health;
  logic [rgbts_pkg::VAL_W-1:0]          in_reward;
  logic [rgbts_pkg::VAL_W-1:0]          in_waypoint;
  logic                                 in_live;
  logic                                 in_stealthy;
  logic                                 in_revealed;
  logic                                 in_last;
  logic                                 out_valid;
  logic                                 out_stall;
  logic                                 out_found;
  logic [rgbts_pkg::SLOT_W-1:0]         out_chosen_slot;
  logic [rgbts_pkg::GEN_W-1:0]          out_chosen_gen;

  rgbts_pkg::cfg_t                      settings;
  logic signed [rgbts_pkg::SCORE_W-1:0] lead_score;
  logic [rgbts_pkg::PROG_W-1:0]         lead_prog;
  logic [rgbts_pkg::SLOT_W-1:0]         best_slot;
  logic [rgbts_pkg::GEN_W-1:0]          best_gen;
  logic                                 have_best;
  verdict_t                             pending_verdicts[$];
  int                                   mismatch_count;
  int                                   cycle_count;
  bit                                   steady_flow;

  range_gated_best_target_select u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_slot_id      (in_slot_id),
    .in_gen_tag      (in_gen_tag),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_health       (in_health),
    .in_reward       (in_reward),
    .in_waypoint     (in_waypoint),
    .in_live         (in_live),
    .in_stealthy     (in_stealthy),
    .in_revealed     (in_revealed),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_chosen_slot (out_chosen_slot),
    .out_chosen_gen  (out_chosen_gen)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void clear_best();
    lead_score = {1'b1, {(rgbts_pkg::SCORE_W-1){1'b0}}};
    lead_prog  = '0;
    best_slot  = '0;
    best_gen   = '0;
    have_best  = 1'b0;
  endfunction

  // Running-best update for one accepted item; a closing item queues a result.
  function automatic void weigh_candidate(input rgbts_pkg::item_t it);
    longint                               dx;
    longint                               dy;
    longint                               dist_sq;
    longint                               reach_sq;
    longint                               raw_score;
    logic signed [rgbts_pkg::SCORE_W-1:0] score;
    logic [rgbts_pkg::PROG_W-1:0]         progress;
    logic                                 counts;
    verdict_t                             v;
    progress = rgbts_pkg::PROG_W'(longint'(it.waypoint) * rgbts_pkg::PROGRESS_STEP);
    counts = it.live && (int'(it.slot_id) < rgbts_pkg::SLOT_COUNT);
    if (counts && !settings.ignore_stealth && it.stealthy && !it.revealed) begin
      counts = 1'b0;
    end
    dx = longint'($signed(settings.center_x)) - longint'($signed(it.pos_x));
    dy = longint'($signed(settings.center_y)) - longint'($signed(it.pos_y));
    dist_sq = dx * dx + dy * dy;
    reach_sq = longint'(settings.reach) * longint'(settings.reach);
    if (counts && dist_sq <= reach_sq) begin
      unique case (settings.score_mode)
        rgbts_pkg::MODE_LAST:      raw_score = -longint'(progress);
        rgbts_pkg::MODE_CLOSEST:   raw_score = -dist_sq;
        rgbts_pkg::MODE_STRONGEST: raw_score = longint'(it.health);
        rgbts_pkg::MODE_WEAKEST:   raw_score = -longint'(it.health);
        rgbts_pkg::MODE_REWARD:    raw_score = longint'(it.reward);
        default:                   raw_score = longint'(progress);
      endcase
      score = rgbts_pkg::SCORE_W'(raw_score);
      if (!have_best || score > lead_score ||
          (score == lead_score && progress > lead_prog)) begin
        lead_score = score;
        lead_prog  = progress;
        best_slot  = it.slot_id;
        best_gen   = it.gen_tag;
        have_best  = 1'b1;
      end
    end
    if (it.last) begin
      v.found = have_best;
      v.slot  = have_best ? best_slot : '0;
      v.gen   = have_best ? best_gen : '0;
      pending_verdicts.push_back(v);
      clear_best();
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %0h, wanted %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing outstanding", longint'(out_found), 64'sd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_found !== want.found) begin
          report_mismatch("found", longint'(out_found), longint'(want.found));
        end
        if (out_chosen_slot !== want.slot) begin
          report_mismatch("chosen_slot", longint'(out_chosen_slot), longint'(want.slot));
        end
        if (out_chosen_gen !== want.gen) begin
          report_mismatch("chosen_gen", longint'(out_chosen_gen), longint'(want.gen));
        end
      end
    end
  end

  // Result side: a fresh stall is drawn for every result taken.
  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  task automatic send_item(input rgbts_pkg::item_t it);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_slot_id  <= it.slot_id;
    in_gen_tag  <= it.gen_tag;
    in_pos_x    <= it.pos_x;
    in_pos_y    <= it.pos_y;
    in_health   <= it.health;
    in_reward   <= it.reward;
    in_waypoint <= it.waypoint;
    in_live     <= it.live;
    in_stealthy <= it.stealthy;
    in_revealed <= it.revealed;
    in_last     <= it.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    weigh_candidate(it);
  endtask

  // Waits until every search has reported and the pipeline has emptied.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [rgbts_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rgbts_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input rgbts_pkg::cfg_t c);
    write_register(rgbts_pkg::CFG_CENTER_X, c.center_x);
    write_register(rgbts_pkg::CFG_CENTER_Y, c.center_y);
    write_register(rgbts_pkg::CFG_REACH, c.reach);
    write_register(rgbts_pkg::CFG_SCORE_MODE, rgbts_pkg::CFG_DATA_W'(c.score_mode));
    write_register(rgbts_pkg::CFG_IGNORE_STEALTH,
                   rgbts_pkg::CFG_DATA_W'(c.ignore_stealth));
    cfg_wr_en <= 1'b0;
    settings = c;
  endtask

  function automatic rgbts_pkg::cfg_t make_settings(input int cx, input int cy,
                                                    input int reach,
                                                    input logic [rgbts_pkg::MODE_W-1:0] mode,
                                                    input bit ignore);
    rgbts_pkg::cfg_t c;
    c.center_x       = rgbts_pkg::COORD_W'(cx);
    c.center_y       = rgbts_pkg::COORD_W'(cy);
    c.reach          = rgbts_pkg::VAL_W'(reach);
    c.score_mode     = mode;
    c.ignore_stealth = ignore;
    return c;
  endfunction

  function automatic rgbts_pkg::item_t make_item(input int slot, input int x, input int y,
                                                 input int health, input int reward,
                                                 input int wp, input bit closing);
    rgbts_pkg::item_t it;
    it.slot_id  = rgbts_pkg::SLOT_W'(slot);
    it.gen_tag  = rgbts_pkg::GEN_W'($urandom);
    it.pos_x    = rgbts_pkg::COORD_W'(x);
    it.pos_y    = rgbts_pkg::COORD_W'(y);
    it.health   = rgbts_pkg::VAL_W'(health);
    it.reward   = rgbts_pkg::VAL_W'(reward);
    it.waypoint = rgbts_pkg::VAL_W'(wp);
    it.live     = 1'b1;
    it.stealthy = 1'b0;
    it.revealed = 1'b0;
    it.last     = closing;
    return it;
  endfunction

  function automatic logic signed [rgbts_pkg::COORD_W-1:0] clamp_coord(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return rgbts_pkg::COORD_W'(v);
  endfunction

  // Small values and the extremes come up often so that equal scores occur.
  function automatic logic [rgbts_pkg::VAL_W-1:0] pick_value();
    unique case ($urandom_range(0, 3))
      0:       return rgbts_pkg::VAL_W'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return rgbts_pkg::VAL_W'($urandom);
    endcase
  endfunction

  function automatic rgbts_pkg::item_t rand_candidate(input bit closing);
    rgbts_pkg::item_t it;
    int               span;
    span = (settings.reach > 3000) ? 3000 : int'(settings.reach);
    it.slot_id = rgbts_pkg::SLOT_W'($urandom);
    it.gen_tag = rgbts_pkg::GEN_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      it.pos_x = clamp_coord(int'($signed(settings.center_x)) +
                             int'($urandom_range(0, 2 * span)) - span);
      it.pos_y = clamp_coord(int'($signed(settings.center_y)) +
                             int'($urandom_range(0, 2 * span)) - span);
    end else begin
      it.pos_x = rgbts_pkg::COORD_W'($urandom);
      it.pos_y = rgbts_pkg::COORD_W'($urandom);
    end
    it.health   = pick_value();
    it.reward   = pick_value();
    it.waypoint = pick_value();
    it.live     = ($urandom_range(0, 7) != 0);
    it.stealthy = ($urandom_range(0, 2) == 0);
    it.revealed = 1'($urandom_range(0, 1));
    it.last     = closing;
    return it;
  endfunction

  // Reset configuration: zero reach admits only a candidate on the centre.
  task automatic test_reset_defaults();
    rgbts_pkg::item_t it;
    it = make_item(1023, 0, 0, 65535, 65535, 65535, 1'b1);
    it.gen_tag = 16'hFFFF;
    send_item(it);
    it = make_item(0, 1, 0, 0, 0, 0, 1'b1);
    it.gen_tag = 16'h0000;
    send_item(it);
    it = make_item(5, 0, 0, 7, 7, 7, 1'b1);
    it.live = 1'b0;
    send_item(it);
  endtask

  // Corner centre and full reach: a distance exactly on the reach is admitted.
  task automatic test_range_gate();
    rgbts_pkg::item_t it;
    settle_block();
    apply_settings(make_settings(-32768, -32768, 65535, rgbts_pkg::MODE_FIRST, 1'b0));
    send_item(make_item(1, 32767, -32768, 0, 0, 0, 1'b0));
    send_item(make_item(2, 32767, 32767, 0, 0, 65535, 1'b0));
    it = make_item(3, -32768, -32768, 0, 0, 65535, 1'b1);
    it.live = 1'b0;
    send_item(it);
  endtask

  task automatic test_stealth();
    rgbts_pkg::item_t it;
    for (int ignore = 0; ignore < 2; ignore++) begin
      settle_block();
      apply_settings(make_settings(0, 0, 100, rgbts_pkg::MODE_REWARD, ignore[0]));
      it = make_item(10, 5, 5, 1, 65535, 1, 1'b0);
      it.stealthy = 1'b1;
      send_item(it);
      it = make_item(11, -5, 5, 1, 5, 1, 1'b0);
      it.stealthy = 1'b1;
      it.revealed = 1'b1;
      send_item(it);
      send_item(make_item(12, 5, -5, 1, 3, 1, 1'b1));
    end
  endtask

  // Two candidates whose order differs under every mode, then equal scores.
  task automatic test_score_modes();
    logic [rgbts_pkg::MODE_W-1:0] mode;
    for (int m = 0; m <= int'(MODE_SPARE_6); m++) begin
      mode = rgbts_pkg::MODE_W'(m);
      settle_block();
      apply_settings(make_settings(0, 0, 65535, mode, 1'b0));
      send_item(make_item(21, 10, 0, 100, 7, 5, 1'b0));
      send_item(make_item(22, 3, 4, 50, 9, 9, 1'b1));
    end
    settle_block();
    apply_settings(make_settings(0, 0, 65535, rgbts_pkg::MODE_STRONGEST, 1'b0));
    send_item(make_item(31, 1, 1, 100, 0, 5, 1'b0));
    send_item(make_item(32, 2, 2, 100, 0, 9, 1'b1));
  endtask

  task automatic test_random_searches();
    rgbts_pkg::cfg_t c;
    int              sent;
    int              len;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      unique case (phase)
        0: c = make_settings(-32768, 32767, 65535, rgbts_pkg::MODE_CLOSEST, 1'b1);
        1: c = make_settings(32767, 32767, 0, MODE_SPARE_7, 1'b0);
        default: begin
          c.center_x       = rgbts_pkg::COORD_W'($urandom);
          c.center_y       = rgbts_pkg::COORD_W'($urandom);
          c.reach          = $urandom_range(0, 1) ?
                             rgbts_pkg::VAL_W'($urandom_range(0, 400)) :
                             rgbts_pkg::VAL_W'($urandom);
          c.score_mode     = rgbts_pkg::MODE_W'($urandom_range(0, 7));
          c.ignore_stealth = 1'($urandom_range(0, 1));
        end
      endcase
      apply_settings(c);
      steady_flow = (phase % 4 == 2);
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_item(rand_candidate(k == len - 1));
        end
        sent += len;
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= rgbts_pkg::CFG_CENTER_X;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_slot_id  <= '0;
    in_gen_tag  <= '0;
    in_pos_x    <= '0;
    in_pos_y    <= '0;
    in_health   <= '0;
    in_reward   <= '0;
    in_waypoint <= '0;
    in_live     <= 1'b0;
    in_stealthy <= 1'b0;
    in_revealed <= 1'b0;
    in_last     <= 1'b0;
    mismatch_count = 0;
    steady_flow    = 1'b0;
    settings       = make_settings(0, 0, 0, rgbts_pkg::MODE_FIRST, 1'b0);
    clear_best();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_range_gate();
    test_stealth();
    test_score_modes();
    test_random_searches();

    settle_block();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
